>>> hw/rtl/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants, types and the BCD shift-add step for the signed
// integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

    localparam int unsigned VALUE_W        = 32;
    localparam int unsigned NUM_DIGITS     = 10;
    localparam int unsigned DIGIT_W        = 4;
    localparam int unsigned BCD_W          = NUM_DIGITS * DIGIT_W;
    localparam int unsigned DIGIT_IDX_W    = 4;
    localparam int unsigned BITS_PER_STAGE = 8;
    localparam int unsigned DAB_STAGES     = VALUE_W / BITS_PER_STAGE;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] t_bcd;
    typedef logic [VALUE_W-1:0]                 t_mag;
    typedef logic [DIGIT_IDX_W-1:0]             t_digit_idx;

    // One double-dabble step: correct each digit, then shift in one bit.
    function automatic t_bcd dabble_step(input t_bcd bcd_in, input logic bit_in);
        t_bcd adj;
        adj = bcd_in;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (adj[d] >= 4'd5) begin
                adj[d] = adj[d] + 4'd3;
            end
        end
        return t_bcd'({adj[NUM_DIGITS-1:0], bit_in});
    endfunction

endpackage

>>> hw/rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints a signed 32-bit number as decimal ASCII text, one character per
// output beat, with the final character of each number flagged.
// ----------------------------------------------------------------------------
// A number enters on i_value and comes back as 1 to 11 output beats: a
// leading '-' for negative values, then the digits most significant first
// with no leading zeros ('0' alone for zero); o_last_char marks the final
// beat. The most negative value prints exactly as -2147483648. Conversion
// runs in a five-stage pipeline (one stage for sign and magnitude, four
// shift-add-3 stages of eight bits each) that takes a new number every
// cycle while o_ready is high; a finished number leaves the last stage
// for the serializer registers. The character serializer then sends one
// character per cycle while i_ready is high, so a number occupies the
// output for one beat per character; that serializer sets the sustained
// rate, and the pipeline fills behind it while it works.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_ascii_char,
    output logic               o_last_char
);

    localparam int unsigned NSTG = sitda_pkg::DAB_STAGES + 1;
    localparam int unsigned BPS  = sitda_pkg::BITS_PER_STAGE;

    // Pipeline registers; stage 0 holds sign and magnitude
    logic                 r_vld [NSTG];
    logic                 r_neg [NSTG];
    sitda_pkg::t_mag      r_mag [NSTG];
    sitda_pkg::t_bcd      r_bcd [NSTG];

    logic                 s_take [NSTG+1];
    sitda_pkg::t_bcd      n_bcd  [NSTG];
    sitda_pkg::t_mag      n_mag  [NSTG];

    // Serializer registers
    logic                   r_busy;
    logic                   r_minus;
    sitda_pkg::t_digit_idx  r_idx;
    sitda_pkg::t_bcd        r_digits;

    logic                   ser_take;
    logic                   ser_last;
    sitda_pkg::t_digit_idx  n_top;

    // Stage can load when empty or when its content moves on
    always_comb begin
        s_take[NSTG] = ser_take;
        for (int k = NSTG - 1; k >= 0; k--) begin
            s_take[k] = !r_vld[k] || s_take[k+1];
        end
    end

    assign o_ready = s_take[0];

    // Shift eight magnitude bits into the BCD digits per stage
    always_comb begin
        n_bcd[0] = '0;
        n_mag[0] = '0;
        for (int k = 1; k < NSTG; k++) begin
            n_bcd[k] = r_bcd[k-1];
            n_mag[k] = r_mag[k-1];
            for (int b = 0; b < BPS; b++) begin
                n_bcd[k] = sitda_pkg::dabble_step(n_bcd[k], n_mag[k][sitda_pkg::VALUE_W-1]);
                n_mag[k] = {n_mag[k][sitda_pkg::VALUE_W-2:0], 1'b0};
            end
        end
    end

    // Advance pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (s_take[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (s_take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Advance pipeline payload
    always_ff @(posedge i_clk) begin
        if (s_take[0]) begin
            r_neg[0] <= i_value[sitda_pkg::VALUE_W-1];
            r_mag[0] <= i_value[sitda_pkg::VALUE_W-1] ? (32'd0 - 32'(i_value))
                                                     : 32'(i_value);
            r_bcd[0] <= n_bcd[0];
        end
        for (int k = 1; k < NSTG; k++) begin
            if (s_take[k]) begin
                r_neg[k] <= r_neg[k-1];
                r_mag[k] <= n_mag[k];
                r_bcd[k] <= n_bcd[k];
            end
        end
    end

    // Find the most significant nonzero digit of the finished number
    always_comb begin
        n_top = '0;
        for (int d = 0; d < sitda_pkg::NUM_DIGITS; d++) begin
            if (r_bcd[NSTG-1][d] != 4'd0) begin
                n_top = sitda_pkg::DIGIT_IDX_W'(d);
            end
        end
    end

    // Present the current character
    assign ser_last     = !r_minus && (r_idx == '0);
    assign ser_take     = !r_busy || (i_ready && ser_last);
    assign o_valid      = r_busy;
    assign o_last_char  = ser_last;
    assign o_ascii_char = r_minus ? sitda_pkg::ASCII_MINUS
                                  : (sitda_pkg::ASCII_ZERO + {4'd0, r_digits[r_idx]});

    // Load a new number or step to the next character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_minus <= 1'b0;
            r_idx   <= '0;
        end else if (ser_take) begin
            r_busy  <= r_vld[NSTG-1];
            r_minus <= r_neg[NSTG-1];
            r_idx   <= n_top;
        end else if (i_ready) begin
            if (r_minus) begin
                r_minus <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    // Hold digits for the number being sent
    always_ff @(posedge i_clk) begin
        if (ser_take) begin
            r_digits <= r_bcd[NSTG-1];
        end
    end

endmodule
